// File: rtl/otbq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otbq_pkg
// Shared types and constants for the owner tagged bounded queue.
// ----------------------------------------------------------------------------
package otbq_pkg;

	localparam int DEPTH     = 16;
	localparam int AW        = $clog2(DEPTH);
	localparam int CW        = $clog2(DEPTH + 1);
	localparam int DATA_W    = 32;
	localparam int TAG_W     = 16;
	localparam int SEQ_W     = 64;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 2;

	localparam logic [2:0] OP_PUSH   = 3'd0;
	localparam logic [2:0] OP_POP    = 3'd1;
	localparam logic [2:0] OP_MARK   = 3'd2;
	localparam logic [2:0] OP_REMOVE = 3'd3;
	localparam logic [2:0] OP_DRAIN  = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_NOTFOUND  = 3'd3;
	localparam logic [2:0] ST_BUDGET    = 3'd4;
	localparam logic [2:0] ST_EXHAUSTED = 3'd5;
	localparam logic [2:0] ST_CAP       = 3'd6;

	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUDGET   = 2'd1;

	typedef struct packed {
		logic [2:0]        op;
		logic [DATA_W-1:0] payload;
		logic              owner_present;
		logic [TAG_W-1:0]  owner_tag;
		logic [SEQ_W-1:0]  target_id;
		logic [TAG_W-1:0]  drain_tag;
		logic [4:0]        drain_cap;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic              has_entry;
		logic [SEQ_W-1:0]  entry_seq;
		logic [DATA_W-1:0] entry_payload;
		logic              entry_owned;
		logic [TAG_W-1:0]  entry_owner;
		logic              entry_published;
		logic [CW-1:0]     occupancy;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic [SEQ_W-1:0]  seq;
		logic [DATA_W-1:0] payload;
		logic              owned;
		logic [TAG_W-1:0]  owner;
		logic              published;
	} entry_t;

endpackage

// File: rtl/owner_tagged_bounded_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owner_tagged_bounded_queue
// Ordered bounded queue of tagged entries, walked one slot a cycle.
//
//   channel  dir  handshake              item
//   in       in   in_valid / in_stall    in_item_t
//   out      out  out_valid / out_stall  out_item_t
//   cfg      in   cfg_we                 cfg_index, cfg_data
//
// push and unused codes finish in check; pop answers there, then walks the
// slots behind the head; mark walks to its target; remove and drain take a
// counting walk, then an editing walk, on the single walk indexed read port.
// a stalled output holds the walk where it stands.
// reset zeroes count, sets sequence to 1, config to 16; slot data undefined.
// ----------------------------------------------------------------------------
module owner_tagged_bounded_queue import otbq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	typedef enum logic [1:0] {S_IDLE, S_CHECK, S_COUNT, S_WALK} state_t;

	state_t            state_q;
	in_item_t          req_q;
	out_item_t         out_q;
	logic              out_valid_q;
	logic [CW-1:0]     fill_q, idx_q, wr_q, cnt_q, occ_q;
	logic [SEQ_W-1:0]  next_seq_q;
	logic [CFG_W-1:0]  cap_lim_q, budget_q;

	entry_t            mem [DEPTH];
	entry_t            rd, mem_wdata;
	logic              mem_we;
	logic [AW-1:0]     mem_addr;

	logic              can_emit, in_range, hit, walk_hit, full, exhausted;
	logic [CFG_W-1:0]  lim;

	function automatic out_item_t mk(input logic [2:0] st, input logic has,
			input entry_t e, input logic [CW-1:0] occ, input logic lst);
		out_item_t r;
		r.status          = st;
		r.has_entry       = has;
		r.entry_seq       = has ? e.seq : '0;
		r.entry_payload   = '0;
		r.entry_owned     = 1'b0;
		r.entry_owner     = '0;
		r.entry_published = 1'b0;
		r.occupancy       = occ;
		r.last            = lst;
		return r;
	endfunction

	// head item with all of its fields
	function automatic out_item_t mk_pop(input entry_t e, input logic [CW-1:0] occ);
		out_item_t r;
		r                 = mk(ST_OK, 1'b1, e, occ, 1'b1);
		r.entry_payload   = e.payload;
		r.entry_owned     = e.owned;
		r.entry_owner     = e.owned ? e.owner : '0;
		r.entry_published = e.published;
		return r;
	endfunction

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign can_emit  = !out_valid_q || !out_stall;

	assign rd        = mem[idx_q[AW-1:0]];
	assign in_range  = idx_q < fill_q;
	assign hit       = rd.owned && rd.owner == req_q.owner_tag &&
		(req_q.op == OP_REMOVE ? !rd.published : rd.published);
	assign walk_hit  = req_q.op != OP_POP && hit;
	assign lim       = (cap_lim_q > CFG_W'(DEPTH)) ? CFG_W'(DEPTH) : cap_lim_q;
	assign full      = CFG_W'(fill_q) >= lim;
	assign exhausted = next_seq_q == '1;

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = idx_q[AW-1:0];
		mem_wdata = rd;
		case (state_q)
			S_CHECK: begin
				if (can_emit && req_q.op == OP_PUSH && !full && !exhausted) begin
					mem_we              = 1'b1;
					mem_addr            = fill_q[AW-1:0];
					mem_wdata.seq       = next_seq_q;
					mem_wdata.payload   = req_q.payload;
					mem_wdata.owned     = req_q.owner_present;
					mem_wdata.owner     = req_q.owner_present ? req_q.owner_tag : '0;
					mem_wdata.published = 1'b0;
				end
			end
			S_COUNT: begin
				if (can_emit && in_range && req_q.op == OP_MARK &&
						rd.seq == req_q.target_id) begin
					mem_we              = 1'b1;
					mem_wdata.published = 1'b1;
				end
			end
			S_WALK: begin
				if (can_emit && in_range) begin
					if (req_q.op == OP_DRAIN) begin
						mem_we          = hit;
						mem_wdata.owner = req_q.drain_tag;
					end else if (!walk_hit) begin
						mem_we   = 1'b1;
						mem_addr = wr_q[AW-1:0];
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			fill_q      <= '0;
			next_seq_q  <= SEQ_W'(1);
			cap_lim_q   <= CFG_W'(16);
			budget_q    <= CFG_W'(16);
			idx_q       <= '0;
			wr_q        <= '0;
			cnt_q       <= '0;
			occ_q       <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_CAPACITY) begin
				cap_lim_q <= cfg_data;
			end
			if (cfg_we && cfg_index == REG_BUDGET) begin
				budget_q <= cfg_data;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= in_item;
						idx_q   <= '0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (can_emit) begin
						state_q <= S_IDLE;
						case (req_q.op)
							OP_PUSH: begin
								out_valid_q <= 1'b1;
								if (full) begin
									out_q <= mk(ST_FULL, 1'b0, rd, fill_q, 1'b1);
								end else if (exhausted) begin
									out_q <= mk(ST_EXHAUSTED, 1'b0, rd, fill_q, 1'b1);
								end else begin
									out_q <= mk(ST_OK, 1'b1, mem_wdata,
										fill_q + CW'(1), 1'b1);
									fill_q     <= fill_q + CW'(1);
									next_seq_q <= next_seq_q + SEQ_W'(1);
								end
							end
							OP_POP: begin
								out_valid_q <= 1'b1;
								if (fill_q == '0) begin
									out_q <= mk(ST_EMPTY, 1'b0, rd, fill_q, 1'b1);
								end else begin
									out_q   <= mk_pop(rd, fill_q - CW'(1));
									idx_q   <= CW'(1);
									wr_q    <= '0;
									state_q <= S_WALK;
								end
							end
							OP_MARK, OP_REMOVE, OP_DRAIN: begin
								if (CFG_W'(fill_q) > budget_q) begin
									out_valid_q <= 1'b1;
									out_q <= mk(ST_BUDGET, 1'b0, rd, fill_q, 1'b1);
								end else begin
									cnt_q   <= '0;
									state_q <= S_COUNT;
								end
							end
							default: begin
								out_valid_q <= 1'b1;
								out_q <= mk(ST_OK, 1'b0, rd, fill_q, 1'b1);
							end
						endcase
					end
				end
				S_COUNT: begin
					if (can_emit) begin
						if (in_range) begin
							if (req_q.op == OP_MARK && rd.seq == req_q.target_id) begin
								out_valid_q <= 1'b1;
								out_q       <= mk(ST_OK, 1'b0, rd, fill_q, 1'b1);
								state_q     <= S_IDLE;
							end else begin
								cnt_q <= cnt_q + CW'(hit);
								idx_q <= idx_q + CW'(1);
							end
						end else begin
							idx_q <= '0;
							wr_q  <= '0;
							if (req_q.op == OP_MARK) begin
								out_valid_q <= 1'b1;
								out_q       <= mk(ST_NOTFOUND, 1'b0, rd, fill_q, 1'b1);
								state_q     <= S_IDLE;
							end else if (req_q.op == OP_DRAIN &&
									cnt_q > req_q.drain_cap) begin
								out_valid_q <= 1'b1;
								out_q       <= mk(ST_CAP, 1'b0, rd, fill_q, 1'b1);
								state_q     <= S_IDLE;
							end else if (cnt_q == '0) begin
								out_valid_q <= 1'b1;
								out_q       <= mk(ST_OK, 1'b0, rd, fill_q, 1'b1);
								state_q     <= S_IDLE;
							end else begin
								occ_q   <= (req_q.op == OP_REMOVE) ? fill_q - cnt_q : fill_q;
								state_q <= S_WALK;
							end
						end
					end
				end
				S_WALK: begin
					if (can_emit) begin
						if (in_range) begin
							if (walk_hit) begin
								out_valid_q <= 1'b1;
								out_q       <= mk(ST_OK, 1'b1, rd, occ_q, cnt_q == CW'(1));
								cnt_q       <= cnt_q - CW'(1);
							end else if (req_q.op != OP_DRAIN) begin
								wr_q <= wr_q + CW'(1);
							end
							idx_q <= idx_q + CW'(1);
						end else begin
							if (req_q.op != OP_DRAIN) begin
								fill_q <= wr_q;
							end
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_CHECK)
		else $error("accepted item not taken into check");

	a_seq_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_seq_q != '0)
		else $error("sequence id wrapped to zero");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.has_entry |-> out_q.entry_seq == '0)
		else $error("entry id without entry");

	a_walk_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK && req_q.op != OP_POP && !in_range |-> cnt_q == '0)
		else $error("walk ended with matches left");

endmodule
